FILE: rtl/egbw_pkg.sv
// ----------------------------------------------------------------------------
// egbw_pkg - shared types and constants of the Exp-Golomb bit writer
// Operation codes, field widths and the structs that link the stages.
// ----------------------------------------------------------------------------
package egbw_pkg;

   // Operation codes carried by the kind field
   localparam int KIND_W = 2;
   localparam logic [KIND_W-1:0] KIND_RAW   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_UE    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_SE    = 2'd2;
   localparam logic [KIND_W-1:0] KIND_ALIGN = 2'd3;

   // Field and datapath widths
   localparam int VALUE_W   = 32;
   localparam int COUNT_W   = 6;
   localparam int LEN_W     = 6;
   localparam int CODE_W    = 64;
   localparam int BYTE_W    = 8;
   localparam int MAX_BYTES = 8;
   localparam int NBYTE_W   = 4;
   localparam int POS_W     = 3;
   localparam int WIN_W     = CODE_W + BYTE_W;

   // Raw writes never exceed one full word
   localparam logic [COUNT_W-1:0] RAW_MAX_BITS = 6'd32;

   typedef logic [BYTE_W-1:0] byte_type;

   // One formed code: left-aligned bits and their length
   typedef struct packed {
      logic              align;
      logic [LEN_W-1:0]  len;
      logic [CODE_W-1:0] bits;
   } code_type;

   // Bytes completed by one request; entry 0 goes out first
   typedef struct packed {
      logic [NBYTE_W-1:0]          count;
      byte_type [MAX_BYTES-1:0]    bytes;
   } pack_type;

endpackage

FILE: rtl/exp_golomb_bit_writer_top.sv
// Path: a request is registered in the code former, then its bytes are loaded
//   into the result register. Throughput: one request per cycle while each
//   request completes at most one byte and rsp_stall is low; a request that
//   completes more (up to 8 bytes) holds the request channel as they drain.
// Reset: synchronous; clears the partial byte, bit position and all valids.
// ----------------------------------------------------------------------------
// exp_golomb_bit_writer_top - order-0 Exp-Golomb bit writer
// Writes raw bits, ue/se codes and byte-align padding MSB-first as bytes.
// ----------------------------------------------------------------------------
module exp_golomb_bit_writer_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [egbw_pkg::KIND_W-1:0]           req_kind,
   input  logic [egbw_pkg::VALUE_W-1:0]          req_code_value,
   input  logic signed [egbw_pkg::VALUE_W-1:0]   req_signed_value,
   input  logic [egbw_pkg::COUNT_W-1:0]          req_bit_count,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [egbw_pkg::BYTE_W-1:0]           rsp_out_byte,
   output logic                                  rsp_last
);

   logic                          accept;
   logic                          advance;
   logic                          code_valid;
   logic                          free;
   logic [egbw_pkg::POS_W-1:0]    pos;
   egbw_pkg::code_type            code;
   egbw_pkg::pack_type            pack;

   // Move a code into the packer when the result register frees up
   assign advance   = code_valid && free;
   assign req_stall = code_valid && !advance;
   assign accept    = req_valid && !req_stall;

   egbw_code_former u_former (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .advance      (advance),
      .kind         (req_kind),
      .code_value   (req_code_value),
      .signed_value (req_signed_value),
      .bit_count    (req_bit_count),
      .code_valid   (code_valid),
      .code         (code)
   );

   egbw_packer u_packer (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .code    (code),
      .pack    (pack),
      .pos     (pos)
   );

   egbw_byte_queue u_queue (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .pack         (pack),
      .free         (free),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last)
   );

   // Never overwrite bytes that are still waiting to go out
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      advance |-> (!rsp_valid || (rsp_last && !rsp_stall)))
      else $error("byte register loaded while holding undelivered bytes");

   // Padding always lands on a byte boundary
   a_align_boundary: assert property (@(posedge clock) disable iff (reset)
      (advance && code.align) |=> (pos == '0))
      else $error("byte align left a partial byte");

   // A byte that is not last is followed by more bytes of the same request
   a_burst_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_last) |=> rsp_valid)
      else $error("result burst ended without a last byte");

endmodule

FILE: rtl/egbw_code_former.sv
// ----------------------------------------------------------------------------
// egbw_code_former - code formation stage
// Turns a request into a left-aligned bit string and its length, registered.
// ----------------------------------------------------------------------------
module egbw_code_former (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  accept,
   input  logic                                  advance,
   input  logic [egbw_pkg::KIND_W-1:0]           kind,
   input  logic [egbw_pkg::VALUE_W-1:0]          code_value,
   input  logic signed [egbw_pkg::VALUE_W-1:0]   signed_value,
   input  logic [egbw_pkg::COUNT_W-1:0]          bit_count,
   output logic                                  code_valid,
   output egbw_pkg::code_type                    code
);

   logic [egbw_pkg::VALUE_W-1:0] mag;
   logic [egbw_pkg::VALUE_W-1:0] ue_m;
   logic [egbw_pkg::VALUE_W-1:0] se_m;
   logic [egbw_pkg::VALUE_W-1:0] m_value;
   logic [egbw_pkg::VALUE_W-1:0] raw_mask;
   logic [egbw_pkg::VALUE_W-1:0] sel_value;
   logic [egbw_pkg::COUNT_W-1:0] raw_len;
   logic [4:0]                   lead;
   logic [egbw_pkg::LEN_W-1:0]   sel_len;
   logic                         sel_align;

   egbw_pkg::code_type code_ff, code_in;
   logic               valid_ff, valid_in;

   // Map the value to code number plus one (saturated)
   always_comb begin
      mag = 32'd0 - signed_value;
      if (code_value == '1) begin
         ue_m = '1;
      end else begin
         ue_m = code_value + 32'd1;
      end
      if (signed_value == 32'sh8000_0000) begin
         se_m = '1;
      end else if (signed_value[31] || (signed_value == 32'sd0)) begin
         se_m = {mag[30:0], 1'b1};
      end else begin
         se_m = {signed_value[30:0], 1'b0};
      end
      m_value = (kind == egbw_pkg::KIND_SE) ? se_m : ue_m;
   end

   // Find the leading one of the code number plus one
   always_comb begin
      lead = 5'd0;
      for (int i = 0; i < egbw_pkg::VALUE_W; i++) begin
         if (m_value[i]) begin
            lead = i[4:0];
         end
      end
   end

   // Select length and value per operation
   always_comb begin
      raw_len   = (bit_count > egbw_pkg::RAW_MAX_BITS) ? egbw_pkg::RAW_MAX_BITS : bit_count;
      raw_mask  = 32'hFFFF_FFFF >> (egbw_pkg::RAW_MAX_BITS - raw_len);
      sel_align = 1'b0;
      case (kind)
         egbw_pkg::KIND_RAW: begin
            sel_len   = raw_len;
            sel_value = code_value & raw_mask;
         end
         egbw_pkg::KIND_UE, egbw_pkg::KIND_SE: begin
            sel_len   = {lead, 1'b1};
            sel_value = m_value;
         end
         default: begin
            sel_align = 1'b1;
            sel_len   = '0;
            sel_value = '0;
         end
      endcase
   end

   // Left-align the code; a zero length shifts everything out
   always_comb begin
      code_in.align = sel_align;
      code_in.len   = sel_len;
      code_in.bits  = {32'd0, sel_value} << (7'd64 - {1'b0, sel_len});
   end

   // Hold the stage until the packer takes it
   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         code_ff <= code_in;
      end
   end

   assign code_valid = valid_ff;
   assign code       = code_ff;

endmodule

FILE: rtl/egbw_packer.sv
// ----------------------------------------------------------------------------
// egbw_packer - bit packer
// Merges a code behind the partial byte and splits off completed bytes.
// ----------------------------------------------------------------------------
module egbw_packer (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           advance,
   input  egbw_pkg::code_type             code,
   output egbw_pkg::pack_type             pack,
   output logic [egbw_pkg::POS_W-1:0]     pos
);

   // Partial byte kept left-aligned: the oldest bit sits in bit 6
   logic [6:0]                    partial_ff, partial_in;
   logic [egbw_pkg::POS_W-1:0]    pos_ff, pos_in;

   logic [egbw_pkg::LEN_W-1:0]    pad_len;
   logic [egbw_pkg::LEN_W-1:0]    len;
   logic [egbw_pkg::WIN_W-1:0]    window;
   logic [6:0]                    total;
   logic [egbw_pkg::NBYTE_W-1:0]  nbytes;
   egbw_pkg::byte_type            chunk [0:egbw_pkg::MAX_BYTES];

   // Merge the partial byte and the new code into one window
   always_comb begin
      pad_len = (pos_ff == '0) ? '0 : (6'd8 - {3'd0, pos_ff});
      len     = code.align ? pad_len : code.len;
      window  = {partial_ff, 1'b0, 64'd0} | ({code.bits, 8'd0} >> pos_ff);
      total   = {4'd0, pos_ff} + {1'b0, len};
      nbytes  = total[6:3];
      for (int k = 0; k <= egbw_pkg::MAX_BYTES; k++) begin
         chunk[k] = window[egbw_pkg::WIN_W-1-8*k -: 8];
      end
   end

   // Split off completed bytes, keep the remainder
   always_comb begin
      pack.count = nbytes;
      for (int k = 0; k < egbw_pkg::MAX_BYTES; k++) begin
         pack.bytes[k] = chunk[k];
      end
      partial_in = chunk[nbytes][7:1];
      pos_in     = total[2:0];
   end

   // Advance the bit state when a code is packed
   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff <= '0;
         pos_ff     <= '0;
      end else if (advance) begin
         partial_ff <= partial_in;
         pos_ff     <= pos_in;
      end
   end

   assign pos = pos_ff;

endmodule

FILE: rtl/egbw_byte_queue.sv
// ----------------------------------------------------------------------------
// egbw_byte_queue - result byte register
// Holds one request's bytes; delivers one per cycle while rsp_stall is low.
// ----------------------------------------------------------------------------
module egbw_byte_queue (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           advance,
   input  egbw_pkg::pack_type             pack,
   output logic                           free,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [egbw_pkg::BYTE_W-1:0]    rsp_out_byte,
   output logic                           rsp_last
);

   logic [egbw_pkg::NBYTE_W-1:0]                   cnt_ff, cnt_in;
   egbw_pkg::byte_type [egbw_pkg::MAX_BYTES-1:0]   bytes_ff, bytes_in;
   logic                                           pop;

   // Free when empty or once the last held byte leaves this cycle
   assign pop  = (cnt_ff != '0) && !rsp_stall;
   assign free = (cnt_ff == '0) || ((cnt_ff == 4'd1) && !rsp_stall);

   // Load a new request or drop the delivered byte
   always_comb begin
      cnt_in   = cnt_ff;
      bytes_in = bytes_ff;
      if (advance) begin
         cnt_in   = pack.count;
         bytes_in = pack.bytes;
      end else if (pop) begin
         cnt_in = cnt_ff - 4'd1;
         for (int k = 0; k < egbw_pkg::MAX_BYTES - 1; k++) begin
            bytes_in[k] = bytes_ff[k+1];
         end
         bytes_in[egbw_pkg::MAX_BYTES-1] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      bytes_ff <= bytes_in;
   end

   assign rsp_valid    = (cnt_ff != '0);
   assign rsp_last     = (cnt_ff == 4'd1);
   assign rsp_out_byte = bytes_ff[0];

endmodule

FILE: test/egbw_stream_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// egbw_stream_checker - byte stream predictor and comparator
// Watches both channels of the Exp-Golomb bit writer, rebuilds the expected
// byte stream from each accepted request and compares every result in order.
// ----------------------------------------------------------------------------
module egbw_stream_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   input  logic                                  req_stall,
   input  logic [egbw_pkg::KIND_W-1:0]           req_kind,
   input  logic [egbw_pkg::VALUE_W-1:0]          req_code_value,
   input  logic signed [egbw_pkg::VALUE_W-1:0]   req_signed_value,
   input  logic [egbw_pkg::COUNT_W-1:0]          req_bit_count,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   input  logic [egbw_pkg::BYTE_W-1:0]           rsp_out_byte,
   input  logic                                  rsp_last,
   output int                                    mismatch_count,
   output int                                    pending_bytes,
   output int                                    matched_bytes
);

   // Largest code number the unsigned code can carry
   localparam logic [egbw_pkg::CODE_W-1:0] CODE_NUM_MAX = 64'd4294967294;

   typedef struct {
      egbw_pkg::byte_type value;
      logic               last;
   } stream_byte_type;

   // Bytes still owed by the block, oldest first
   stream_byte_type stream_q[$];

   // Unfinished byte: bits right-aligned, oldest bit most significant
   logic [egbw_pkg::BYTE_W-1:0] frag_bits;
   logic [3:0]                  frag_len;

   // Shift one bit into the unfinished byte, queue it when it fills
   task automatic emit_bit(input logic b);
      stream_byte_type sb;
      frag_bits = {frag_bits[egbw_pkg::BYTE_W-2:0], b};
      frag_len  = frag_len + 4'd1;
      if (frag_len == 4'(egbw_pkg::BYTE_W)) begin
         sb.value = frag_bits;
         sb.last  = 1'b0;
         stream_q.insert(stream_q.size(), sb);
         frag_bits = '0;
         frag_len  = '0;
      end
   endtask

   // Write the low n bits of v, most significant first
   task automatic emit_field(input logic [egbw_pkg::CODE_W-1:0] v, input int n);
      int i;
      for (i = n - 1; i >= 0; i--)
         emit_bit(v[i]);
   endtask

   // Write an order-0 Exp-Golomb code: leading zeros, then code+1
   task automatic emit_exp_golomb(input logic [egbw_pkg::CODE_W-1:0] code);
      logic [egbw_pkg::CODE_W-1:0] num;
      int lead;
      if (code > CODE_NUM_MAX)
         code = CODE_NUM_MAX;
      num  = code + 64'd1;
      lead = 0;
      while (lead < 63 && (num >> (lead + 1)) != 0)
         lead++;
      emit_field('0, lead);
      emit_field(num, lead + 1);
   endtask

   // Work out every byte that one request completes
   task automatic predict_request(input logic [egbw_pkg::KIND_W-1:0] kind,
                                  input logic [egbw_pkg::VALUE_W-1:0] cv,
                                  input logic [egbw_pkg::VALUE_W-1:0] sv,
                                  input logic [egbw_pkg::COUNT_W-1:0] cnt);
      int                           start_size;
      int                           raw_n;
      logic [egbw_pkg::CODE_W-1:0]  mag;
      logic [egbw_pkg::VALUE_W-1:0] neg;
      start_size = stream_q.size();
      case (kind)
         egbw_pkg::KIND_RAW: begin
            raw_n = (cnt > egbw_pkg::RAW_MAX_BITS) ? int'(egbw_pkg::RAW_MAX_BITS)
                                                   : int'(cnt);
            emit_field({32'd0, cv}, raw_n);
         end
         egbw_pkg::KIND_UE: begin
            emit_exp_golomb({32'd0, cv});
         end
         egbw_pkg::KIND_SE: begin
            // map negative to -2s and positive to 2s-1; the minimum lands on 2^32
            if (sv[egbw_pkg::VALUE_W-1]) begin
               neg = ~sv + 32'd1;
               mag = {32'd0, neg};
               emit_exp_golomb(mag << 1);
            end else if (sv == '0) begin
               emit_exp_golomb('0);
            end else begin
               emit_exp_golomb({32'd0, sv} * 64'd2 - 64'd1);
            end
         end
         egbw_pkg::KIND_ALIGN: begin
            while (frag_len != 0)
               emit_bit(1'b0);
         end
      endcase
      if (stream_q.size() > start_size)
         stream_q[stream_q.size() - 1].last = 1'b1;
   endtask

   // Compare results first, then predict: no request answers in its own cycle
   always @(posedge clock) begin
      stream_byte_type want;
      if (reset) begin
         stream_q.delete();
         frag_bits      = '0;
         frag_len       = '0;
         mismatch_count = 0;
         matched_bytes  = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (stream_q.size() == 0) begin
               $error("rsp_out_byte: expected nothing, actual 0x%02h (last %0b)",
                      rsp_out_byte, rsp_last);
               mismatch_count++;
            end else begin
               want = stream_q.pop_front();
               if (rsp_out_byte !== want.value) begin
                  $error("rsp_out_byte: expected 0x%02h, actual 0x%02h",
                         want.value, rsp_out_byte);
                  mismatch_count++;
               end
               if (rsp_last !== want.last) begin
                  $error("rsp_last: expected %0b, actual %0b", want.last, rsp_last);
                  mismatch_count++;
               end
               matched_bytes++;
            end
         end
         if (req_valid && !req_stall)
            predict_request(req_kind, req_code_value, req_signed_value, req_bit_count);
      end
      pending_bytes = stream_q.size();
   end

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top - testbench of the Exp-Golomb bit writer
// Drives directed corner requests and then random code sequences with
// random gaps and result stalls, including one long hold-off of the result
// channel; the stream checker predicts and compares every byte.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int RANDOM_REQUESTS = 238;
   localparam int HOLD_OFF_AT     = 100;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int DRAIN_CYCLES    = 16;
   localparam int CYCLE_LIMIT     = 500000;

   logic                                 clock = 1'b0;
   logic                                 reset;
   logic                                 req_valid;
   logic                                 req_stall;
   logic [egbw_pkg::KIND_W-1:0]          req_kind;
   logic [egbw_pkg::VALUE_W-1:0]         req_code_value;
   logic signed [egbw_pkg::VALUE_W-1:0]  req_signed_value;
   logic [egbw_pkg::COUNT_W-1:0]         req_bit_count;
   logic                                 rsp_valid;
   logic                                 rsp_stall;
   logic [egbw_pkg::BYTE_W-1:0]          rsp_out_byte;
   logic                                 rsp_last;

   int mismatch_count;
   int pending_bytes;
   int matched_bytes;
   int kind_count [4];
   int req_stall_cycles;
   bit hold_off_pending;
   bit hold_off_served;

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   exp_golomb_bit_writer_top uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_code_value   (req_code_value),
      .req_signed_value (req_signed_value),
      .req_bit_count    (req_bit_count),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_last         (rsp_last)
   );

   egbw_stream_checker stream_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_code_value   (req_code_value),
      .req_signed_value (req_signed_value),
      .req_bit_count    (req_bit_count),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_last         (rsp_last),
      .mismatch_count   (mismatch_count),
      .pending_bytes    (pending_bytes),
      .matched_bytes    (matched_bytes)
   );

   // Idle cycles before a request: mostly none, a few long
   function automatic int pick_gap(input bit busy);
      int r;
      if (busy)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 85)
         return $urandom_range(1, 3);
      if (r < 96)
         return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [egbw_pkg::KIND_W-1:0] pick_kind();
      int r;
      r = $urandom_range(0, 99);
      if (r < 30)
         return egbw_pkg::KIND_RAW;
      if (r < 62)
         return egbw_pkg::KIND_UE;
      if (r < 92)
         return egbw_pkg::KIND_SE;
      return egbw_pkg::KIND_ALIGN;
   endfunction

   // Mostly short codes, with full-width values and saturation points mixed in
   function automatic logic [egbw_pkg::VALUE_W-1:0] rand_code_value();
      int sel;
      int w;
      sel = $urandom_range(0, 9);
      w   = $urandom_range(1, 32);
      if (sel < 4)
         return $urandom_range(0, 300);
      if (sel < 6)
         return $urandom >> (32 - w);
      if (sel == 6)
         return $urandom;
      if (sel == 7)
         return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'hFFFF_FFFE;
      return (32'd1 << $urandom_range(0, 31)) - 32'($urandom_range(0, 2));
   endfunction

   function automatic logic signed [egbw_pkg::VALUE_W-1:0] rand_signed_value();
      int sel;
      int w;
      logic signed [egbw_pkg::VALUE_W-1:0] mag;
      sel = $urandom_range(0, 9);
      w   = $urandom_range(1, 31);
      if (sel < 4)
         return int'($urandom_range(0, 600)) - 300;
      if (sel < 6) begin
         mag = $urandom >> (32 - w);
         return $urandom_range(0, 1) ? -mag : mag;
      end
      if (sel == 6)
         return $urandom;
      if (sel == 7) begin
         case ($urandom_range(0, 2))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            default: return 32'sh8000_0001;
         endcase
      end
      mag = 32'sd1 <<< $urandom_range(0, 30);
      return $urandom_range(0, 1) ? -mag : mag;
   endfunction

   function automatic logic [egbw_pkg::COUNT_W-1:0] rand_bit_count();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80)
         return 6'($urandom_range(1, 32));
      if (r < 90)
         return 6'($urandom_range(33, 63));
      return '0;
   endfunction

   // Offer one request at the falling edge and hold it until accepted
   task automatic send_request(input logic [egbw_pkg::KIND_W-1:0] kind,
                               input logic [egbw_pkg::VALUE_W-1:0] cv,
                               input logic [egbw_pkg::VALUE_W-1:0] sv,
                               input logic [egbw_pkg::COUNT_W-1:0] cnt,
                               input bit busy);
      int gap;
      gap = pick_gap(busy);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_kind         <= kind;
      req_code_value   <= cv;
      req_signed_value <= sv;
      req_bit_count    <= cnt;
      kind_count[kind]++;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      @(negedge clock);
   endtask

   // Result side: random stall bursts, one long hold-off on request
   initial begin : result_side
      int run;
      int hold;
      int r;
      rsp_stall <= 1'b0;
      @(negedge clock);
      while (reset)
         @(negedge clock);
      forever begin
         if (hold_off_pending && !hold_off_served) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            hold_off_served = 1'b1;
         end
         run = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
         rsp_stall <= 1'b0;
         repeat (run) @(negedge clock);
         r = $urandom_range(0, 99);
         if (r < 20)
            hold = 0;
         else if (r < 75)
            hold = $urandom_range(1, 2);
         else if (r < 94)
            hold = $urandom_range(3, 8);
         else
            hold = $urandom_range(10, 30);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
      end
   end

   // Count cycles the block pushed back on the request side
   always @(posedge clock) begin
      if (!reset && req_valid && req_stall)
         req_stall_cycles++;
   end

   // Stop a hung run
   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   initial begin : stimulus
      int idx;
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_kind         <= egbw_pkg::KIND_RAW;
      req_code_value   <= '0;
      req_signed_value <= '0;
      req_bit_count    <= '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed corners: raw widths, clamped counts, saturation, alignment
      send_request(egbw_pkg::KIND_RAW,   32'h0000_00A5, $urandom, 6'd8,  1'b0);
      send_request(egbw_pkg::KIND_RAW,   $urandom,      $urandom, 6'd0,  1'b0);
      send_request(egbw_pkg::KIND_RAW,   32'hFFFF_FFFF, $urandom, 6'd32, 1'b0);
      send_request(egbw_pkg::KIND_RAW,   32'h1234_5678, $urandom, 6'd63, 1'b0);
      send_request(egbw_pkg::KIND_RAW,   32'h0000_0001, $urandom, 6'd33, 1'b0);
      send_request(egbw_pkg::KIND_RAW,   32'h0000_0001, $urandom, 6'd1,  1'b0);
      send_request(egbw_pkg::KIND_ALIGN, $urandom,      $urandom, 6'($urandom), 1'b0);
      send_request(egbw_pkg::KIND_ALIGN, $urandom,      $urandom, 6'($urandom), 1'b0);
      send_request(egbw_pkg::KIND_UE,    32'd0,         $urandom, 6'($urandom), 1'b0);
      send_request(egbw_pkg::KIND_UE,    32'd1,         $urandom, 6'($urandom), 1'b0);
      send_request(egbw_pkg::KIND_UE,    32'hFFFF_FFFF, $urandom, 6'($urandom), 1'b0);
      send_request(egbw_pkg::KIND_UE,    32'hFFFF_FFFE, $urandom, 6'($urandom), 1'b0);
      send_request(egbw_pkg::KIND_UE,    32'h7FFF_FFFF, $urandom, 6'($urandom), 1'b0);
      send_request(egbw_pkg::KIND_SE,    $urandom, 32'sd0,         6'($urandom), 1'b0);
      send_request(egbw_pkg::KIND_SE,    $urandom, 32'sd1,         6'($urandom), 1'b0);
      send_request(egbw_pkg::KIND_SE,    $urandom, -32'sd1,        6'($urandom), 1'b0);
      send_request(egbw_pkg::KIND_SE,    $urandom, 32'sh7FFF_FFFF, 6'($urandom), 1'b0);
      send_request(egbw_pkg::KIND_SE,    $urandom, 32'sh8000_0001, 6'($urandom), 1'b0);
      send_request(egbw_pkg::KIND_SE,    $urandom, 32'sh8000_0000, 6'($urandom), 1'b0);
      send_request(egbw_pkg::KIND_RAW,   32'h0000_0000, $urandom, 6'd7,  1'b0);
      send_request(egbw_pkg::KIND_RAW,   32'h0000_003F, $urandom, 6'd6,  1'b0);
      send_request(egbw_pkg::KIND_ALIGN, $urandom,      $urandom, 6'($urandom), 1'b0);

      // Random code sequences; keep offering back to back during the hold-off
      for (idx = 0; idx < RANDOM_REQUESTS; idx++) begin
         if (idx == HOLD_OFF_AT)
            hold_off_pending = 1'b1;
         send_request(pick_kind(), rand_code_value(), rand_signed_value(), rand_bit_count(),
                      (idx % 70) < 15 || (hold_off_pending && !hold_off_served));
      end
      req_valid <= 1'b0;

      // Drain outstanding bytes, then watch for strays
      while (pending_bytes != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Requests: %0d raw, %0d ue, %0d se, %0d align; %0d bytes compared",
               kind_count[egbw_pkg::KIND_RAW], kind_count[egbw_pkg::KIND_UE],
               kind_count[egbw_pkg::KIND_SE], kind_count[egbw_pkg::KIND_ALIGN],
               matched_bytes);
      $display("Result side held off %0d cycles; request side pushed back %0d cycles",
               HOLD_OFF_CYCLES, req_stall_cycles);
      if (mismatch_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
